// ===== rtl/core/kmp_pkg.sv =====
// shared types and constants for the kmp stream matcher
// used by kmp_ctrl, kmp_dp and kmp_stream_matcher_top; no dependencies
`default_nettype none

package kmp_pkg;

  localparam int PatternMax = 64;
  localparam int PosWidth   = 32;
  localparam int LenWidth   = $clog2(PatternMax + 1);
  localparam int AddrWidth  = $clog2(PatternMax);

  typedef enum logic [1:0] {
    FuncStart   = 2'd0,
    FuncAppend  = 2'd1,
    FuncText    = 2'd2,
    FuncRestart = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic                match_found;
    logic [PosWidth-1:0] match_start;
    logic [LenWidth-1:0] matched_length;
    logic [1:0]          status;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic fixup;
    logic emit;
  } kmp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic simple;
    logic walk_done;
    logic full_match;
  } kmp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/kmp_ctrl.sv =====
// sequencing state machine for the kmp stream matcher
// depends on kmp_pkg; drives kmp_dp through kmp_cmd_t
`default_nettype none

module kmp_ctrl
  import kmp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  kmp_status_t status_i,
  output kmp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFixup,
    StDone
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.capture = in_valid_i && (state_q == StIdle);
    cmd_o.step    = (state_q == StWalk);
    cmd_o.fixup   = (state_q == StFixup);
    cmd_o.emit    = (state_q == StDone) && slot_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = status_i.simple ? StDone : StWalk;
        end
      end
      StWalk: begin
        if (status_i.walk_done) begin
          state_d = status_i.full_match ? StFixup : StDone;
        end
      end
      StFixup: begin
        state_d = StDone;
      end
      StDone: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // one item in flight: an accepted transfer closes the input for the next cycle
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_fixup_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFixup) |-> ($past(state_q) == StWalk))
    else $error("fixup not entered from walk");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> (out_valid_o && in_ready_o))
    else $error("emitted result not presented");

endmodule

`default_nettype wire

// ===== rtl/core/kmp_dp.sv =====
// datapath of the kmp stream matcher: pattern and failure memories,
// walk register, search state and result registers; depends on kmp_pkg
`default_nettype none

module kmp_dp
  import kmp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_t         in_data_i,
  input  kmp_cmd_t    cmd_i,
  output kmp_status_t status_o,
  output out_t        out_data_o
);

  logic [7:0]          pat_mem [PatternMax];
  logic [LenWidth-1:0] pre_mem [PatternMax];

  logic [7:0]          pat_rd_q;
  logic [LenWidth-1:0] pre_rd_q;

  func_e               func_q;
  logic [7:0]          byte_q;
  logic [LenWidth-1:0] k_q, k_d;
  logic [LenWidth-1:0] len_q, len_d;
  logic [LenWidth-1:0] build_q, build_d;
  logic [LenWidth-1:0] prog_q, prog_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  out_t                res_q, res_d;
  out_t                out_q;

  logic                wr_en;
  logic [AddrWidth-1:0] wr_addr;
  logic [7:0]          wr_byte;
  logic [LenWidth-1:0] wr_pre;
  logic [LenWidth-1:0] k_dm1;

  logic                mismatch, walk_done, full_match, is_empty, is_full;
  logic [LenWidth-1:0] k_hit;
  logic [PosWidth-1:0] pos_inc;

  assign is_empty   = (len_q == '0);
  assign is_full    = (len_q == LenWidth'(PatternMax));
  assign mismatch   = (pat_rd_q != byte_q);
  assign k_hit      = k_q + {{(LenWidth-1){1'b0}}, !mismatch};
  assign walk_done  = (k_q == '0) || !mismatch;
  assign full_match = walk_done && (func_q == FuncText) && (k_hit == len_q);
  assign pos_inc    = pos_q + PosWidth'(1);
  assign k_dm1      = k_d - LenWidth'(1);

  always_comb begin
    status_o.simple     = !(((in_data_i.func == FuncAppend) && !is_empty && !is_full) ||
                            ((in_data_i.func == FuncText) && !is_empty));
    status_o.walk_done  = walk_done;
    status_o.full_match = full_match;
  end

  always_comb begin
    k_d     = k_q;
    len_d   = len_q;
    build_d = build_q;
    prog_d  = prog_q;
    pos_d   = pos_q;
    res_d   = res_q;
    wr_en   = 1'b0;
    wr_addr = len_q[AddrWidth-1:0];
    wr_byte = byte_q;
    wr_pre  = k_hit;

    if (cmd_i.capture) begin
      res_d.match_found    = 1'b0;
      res_d.match_start    = '0;
      res_d.matched_length = prog_q;
      res_d.status         = StatOk;
      unique case (in_data_i.func)
        FuncStart: begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_byte = in_data_i.data_byte;
          wr_pre  = '0;
          len_d   = LenWidth'(1);
          build_d = '0;
          prog_d  = '0;
          pos_d   = '0;
          res_d.matched_length = '0;
        end
        FuncAppend: begin
          if (is_empty) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_byte = in_data_i.data_byte;
            wr_pre  = '0;
            len_d   = LenWidth'(1);
            build_d = '0;
          end else if (is_full) begin
            res_d.status = StatFull;
          end else begin
            k_d = build_q;
          end
        end
        FuncText: begin
          if (is_empty) begin
            res_d.status         = StatEmpty;
            res_d.matched_length = '0;
            prog_d               = '0;
            pos_d                = pos_inc;
          end else begin
            k_d = prog_q;
          end
        end
        FuncRestart: begin
          prog_d = '0;
          pos_d  = '0;
          res_d.matched_length = '0;
        end
        default: begin
          prog_d = prog_q;
        end
      endcase
    end else if (cmd_i.step) begin
      if (!walk_done) begin
        // follow the failure link
        k_d = pre_rd_q;
      end else if (func_q == FuncAppend) begin
        wr_en   = 1'b1;
        build_d = k_hit;
        len_d   = len_q + LenWidth'(1);
        res_d.match_found    = 1'b0;
        res_d.match_start    = '0;
        res_d.matched_length = prog_q;
        res_d.status         = StatOk;
      end else if (full_match) begin
        // k_d - 1 addresses the last failure entry for the fixup read
        k_d = k_hit;
      end else begin
        prog_d = k_hit;
        pos_d  = pos_inc;
        res_d.match_found    = 1'b0;
        res_d.match_start    = '0;
        res_d.matched_length = k_hit;
        res_d.status         = StatOk;
      end
    end else if (cmd_i.fixup) begin
      prog_d = pre_rd_q;
      pos_d  = pos_inc;
      res_d.match_found    = 1'b1;
      res_d.match_start    = pos_q - {{(PosWidth-LenWidth){1'b0}}, len_q} + PosWidth'(1);
      res_d.matched_length = pre_rd_q;
      res_d.status         = StatOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      build_q <= '0;
      prog_q  <= '0;
      pos_q   <= '0;
    end else begin
      len_q   <= len_d;
      build_q <= build_d;
      prog_q  <= prog_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_data_i.func;
      byte_q <= in_data_i.data_byte;
    end
    k_q   <= k_d;
    res_q <= res_d;
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  // memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pat_mem[wr_addr] <= wr_byte;
      pre_mem[wr_addr] <= wr_pre;
    end
    pat_rd_q <= pat_mem[k_d[AddrWidth-1:0]];
    pre_rd_q <= pre_mem[k_dm1[AddrWidth-1:0]];
  end

  assign out_data_o = out_q;

  a_prog_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (prog_q < len_q))
    else $error("search progress reached pattern length");

  a_build_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) |-> (build_q < len_q))
    else $error("build prefix reached pattern length");

  a_full_only_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && full_match) |=> (cmd_i.fixup && (k_q == len_q)))
    else $error("full match not followed by fixup");

endmodule

`default_nettype wire

// ===== rtl/core/kmp_stream_matcher_top.sv =====
// Knuth-Morris-Pratt stream matcher, top level: a pattern of up to 64 bytes
// loaded one byte per transfer with its failure table built on the fly, then
// text bytes streamed one per transfer, every occurrence (overlaps included)
// reported with its start position. Items are processed one at a time. Start,
// restart, an append to an empty pattern, a byte dropped on a full pattern and
// text with no pattern go straight from capture to the result hand-off. Other
// pattern appends and text bytes first run the failure walk, one link per cycle
// through the registered read port of the pattern and failure memories, then a
// fixup step when the byte completes an occurrence, then the hand-off. Over a
// text stream the walk averages at most two comparisons per byte. A finished
// result sits in the output register, so the next input transfer is taken
// while it waits; a second finished result holds until that register frees.
// Memories hold garbage until written.
// depends on kmp_pkg, kmp_ctrl and kmp_dp
`default_nettype none

module kmp_stream_matcher_top
  import kmp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  // pattern and text items
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  // one result per item
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // command and status between the sequencer and the datapath
  kmp_cmd_t    cmd;
  kmp_status_t dp_status;

  // sequencer: idle, failure walk, full-match fixup, result hand-off
  kmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // datapath: memories, walk register, search state, output register
  kmp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (dp_status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== verif/kmp_stream_matcher_tb.sv =====
// self-checking testbench for kmp_stream_matcher_top: directed and random pattern/text items
// with an in-file scoreboard that predicts every result; depends on kmp_pkg and the rtl
`timescale 1ns / 1ps

module testbench
  import kmp_pkg::*;
();

  localparam int CycleLimit = 1_000_000;
  localparam int NumItems   = 1800;
  localparam int DrainWait  = 100;

  // scoreboard: own copy of the pattern, failure links and search state,
  // plus the queue of results still owed by the block
  class match_scoreboard;
    logic [7:0]          pat_byte  [PatternMax];
    logic [LenWidth-1:0] fail_link [PatternMax];
    int unsigned         pat_len;
    int unsigned         build_len;
    int unsigned         progress;
    logic [PosWidth-1:0] position;
    out_t                owed_q[$];
    int unsigned         failures;

    function new();
      pat_len   = 0;
      build_len = 0;
      progress  = 0;
      position  = '0;
      failures  = 0;
    endfunction

    function void load_first(logic [7:0] b);
      pat_byte[0]  = b;
      fail_link[0] = '0;
      pat_len      = 1;
      build_len    = 0;
    endfunction

    // an input transfer was accepted: work out the result it causes
    function void note_input(in_t item);
      out_t        res;
      int unsigned k;
      logic [7:0]  b;
      res = '0;
      b   = item.data_byte;
      case (item.func)
        FuncStart: begin
          load_first(b);
          progress = 0;
          position = '0;
        end
        FuncAppend: begin
          if (pat_len == 0) begin
            load_first(b);
          end else if (pat_len >= PatternMax) begin
            res.status = StatFull;
          end else begin
            k = build_len;
            while (k != 0 && pat_byte[k] != b) k = 32'(fail_link[k-1]);
            if (pat_byte[k] == b) k++;
            fail_link[pat_len] = LenWidth'(k);
            pat_byte[pat_len]  = b;
            build_len          = k;
            pat_len++;
          end
        end
        FuncText: begin
          if (pat_len == 0) begin
            res.status = StatEmpty;
            progress   = 0;
          end else begin
            k = progress;
            while (k != 0 && pat_byte[k] != b) k = 32'(fail_link[k-1]);
            if (pat_byte[k] == b) k++;
            if (k == pat_len) begin
              res.match_found = 1'b1;
              res.match_start = position - PosWidth'(pat_len - 1);
              k = 32'(fail_link[k-1]);
            end
            progress = k;
          end
          position = position + PosWidth'(1);
        end
        default: begin
          progress = 0;
          position = '0;
        end
      endcase
      res.matched_length = LenWidth'(progress);
      owed_q = {owed_q, res};
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (owed_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: found %0b start %0d length %0d status %0d",
                   got.match_found, got.match_start, got.matched_length, got.status);
        return;
      end
      want = owed_q.pop_front();
      if (got.match_found !== want.match_found || got.match_start !== want.match_start ||
          got.matched_length !== want.matched_length || got.status !== want.status) begin
        failures++;
        if (failures <= 10)
          $display("mismatch (exp/got): found %0b/%0b start %0d/%0d length %0d/%0d status %0d/%0d",
                   want.match_found, got.match_found, want.match_start, got.match_start,
                   want.matched_length, got.matched_length, want.status, got.status);
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  match_scoreboard sb;
  bit              calm;       // when set, neither side inserts idle cycles
  int unsigned     n_sent;
  int unsigned     cycle_count;

  kmp_stream_matcher_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // idle cycles before the next transfer on either side
  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // byte from a small alphabet around base so that matches happen often
  function automatic logic [7:0] alpha(logic [7:0] base, int spread);
    return base ^ 8'($urandom_range(0, spread));
  endfunction

  // one input transfer; called right after a rising edge, returns right after
  // the edge where the transfer took place, with valid still high
  task automatic send(func_e f, logic [7:0] b);
    int   gap;
    in_t  item;
    gap            = pick_gap();
    item.func      = f;
    item.data_byte = b;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(item);
    n_sent++;
  endtask

  // result side: random stalls, every transfer checked against the oldest prediction
  initial begin
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(out_data_o);
    end
  end

  // run limit, far above the slowest legal run
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("** kmp_stream_matcher_top: FAILED **");
    $finish;
  end

  // stimulus
  initial begin
    int          plen;
    int          tlen;
    int          i;
    int          j;
    int          r;
    int          span;
    int          spread;
    logic [7:0]  base;
    logic [7:0]  b;
    logic [7:0]  pat_buf [PatternMax];

    sb         = new();
    calm       = 1'b0;
    n_sent     = 0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    // text before any pattern: flagged, position still moves
    send(FuncText, 8'h00);
    send(FuncText, 8'hFF);
    send(FuncRestart, 8'h5A);
    send(FuncText, 8'hA5);
    // append with nothing loaded behaves as a start but keeps the position
    send(FuncAppend, 8'hAA);
    send(FuncAppend, 8'hAA);
    // overlapping occurrences of "aa"
    send(FuncText, 8'hAA);
    send(FuncText, 8'hAA);
    send(FuncText, 8'hAA);
    send(FuncText, 8'h55);
    // new pattern clears the search, both byte extremes
    send(FuncStart, 8'h00);
    send(FuncAppend, 8'hFF);
    send(FuncText, 8'h00);
    send(FuncText, 8'hFF);
    send(FuncText, 8'h00);
    // pattern grows while a partial match is in flight
    send(FuncAppend, 8'h00);
    send(FuncText, 8'hFF);
    send(FuncText, 8'h00);
    send(FuncText, 8'hFF);
    send(FuncRestart, 8'hFF);
    send(FuncText, 8'h00);
    // single-byte pattern matches on every equal byte
    send(FuncStart, 8'hFF);
    send(FuncText, 8'hFF);
    send(FuncText, 8'hFF);
    send(FuncText, 8'h7F);

    // random part: mostly well-formed load-then-search sequences
    while (n_sent < NumItems) begin
      calm = ($urandom_range(0, 4) == 0);
      base = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 11) == 0) begin
        // full-size pattern, then bytes that no longer fit
        plen   = PatternMax;
        spread = $urandom_range(0, 1);
      end else begin
        plen   = $urandom_range(1, 8);
        spread = $urandom_range(1, 3);
      end
      if ($urandom_range(0, 7) == 0) send(FuncRestart, 8'($urandom_range(0, 255)));
      for (i = 0; i < plen; i++) begin
        pat_buf[i] = alpha(base, spread);
        send(i == 0 ? FuncStart : FuncAppend, pat_buf[i]);
      end
      if (plen == PatternMax) begin
        for (i = $urandom_range(1, 3); i > 0; i--) send(FuncAppend, 8'($urandom_range(0, 255)));
        tlen = $urandom_range(70, 140);
      end else begin
        tlen = $urandom_range(10, 60);
      end

      i = 0;
      while (i < tlen) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          // replay the pattern, or a prefix of it
          span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
          for (j = 0; j < span; j++) send(FuncText, pat_buf[j]);
          i += span;
        end else begin
          if (r < 27) begin
            send(FuncText, 8'($urandom_range(0, 255)));
          end else if (r < 29) begin
            send(FuncRestart, 8'($urandom_range(0, 255)));
          end else if (r < 31) begin
            // append mid-search, flagged once the pattern is full
            if (plen < PatternMax) begin
              b             = alpha(base, spread);
              pat_buf[plen] = b;
              plen++;
              send(FuncAppend, b);
            end else begin
              send(FuncAppend, 8'($urandom_range(0, 255)));
            end
          end else if (r < 32) begin
            send(func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          end else begin
            send(FuncText, alpha(base, spread));
          end
          i++;
        end
      end
    end

    // drain: every owed result, then a wait for anything stray
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    sb.failures += sb.pending();

    if (sb.failures == 0) begin
      $display("** kmp_stream_matcher_top: PASSED **");
    end else begin
      $display("** kmp_stream_matcher_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/kmp_pkg.sv
rtl/core/kmp_ctrl.sv
rtl/core/kmp_dp.sv
rtl/core/kmp_stream_matcher_top.sv
verif/kmp_stream_matcher_tb.sv
